### rtl/lcs_pkg.sv
package lcs_pkg;

    localparam int MAX_LEN   = 64;
    localparam int MAX_VALUE = 100;

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int KIND_W = 2;
    localparam int VAL_W  = 7;
    localparam int LEN_W  = 7;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic [VAL_W-1:0] element;
        logic             empty_res;
        logic             last;
        logic [LEN_W-1:0] length;
    } result_t;

    // engine to top: result push and end of run
    typedef struct packed {
        logic    push;
        logic    done;
        result_t res;
    } eng_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_SCAN2,
        ST_SEEK1,
        ST_PUSH,
        ST_FINISH
    } eng_state_t;

endpackage

### rtl/lcs_ram.sv
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lcs_engine.sv
module lcs_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lcs_pkg::CNT_W-1:0]   cnt1,
    input  logic [lcs_pkg::CNT_W-1:0]   cnt2,
    input  logic [lcs_pkg::VAL_W-1:0]   rdata1,
    input  logic [lcs_pkg::VAL_W-1:0]   rdata2,
    input  logic                        space,
    output logic [lcs_pkg::ADDR_W-1:0]  raddr,
    output lcs_pkg::eng_out_t           eng
);
    import lcs_pkg::*;

    eng_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              rdv_reg, rdv_next;
    logic [ADDR_W-1:0] ridx_reg, ridx_next;
    logic [CNT_W-1:0]  p2_reg, p2_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [MAX_VALUE:0] pres_reg, pres_next;
    logic [VAL_W-1:0]  best_reg, best_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] bi_reg, bi_next;
    logic [ADDR_W-1:0] bj_reg, bj_next;
    logic [VAL_W-1:0]  pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;

    logic [CNT_W-1:0]  limit;
    logic [VAL_W-1:0]  rdata_cur;
    logic              issue;
    logic              scan_idle;
    logic              in_range;
    logic              seek_hit;

    assign limit     = (state_reg == ST_SCAN2) ? cnt2 : cnt1;
    assign rdata_cur = (state_reg == ST_SCAN2) ? rdata2 : rdata1;
    assign issue     = (addr_reg < limit);
    assign scan_idle = !issue && !rdv_reg;
    assign in_range  = (rdata_cur <= VAL_W'(MAX_VALUE));
    assign seek_hit  = rdv_reg && (rdata1 == best_reg);
    assign raddr     = addr_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rdv_reg        <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rdv_reg        <= rdv_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        ridx_reg <= ridx_next;
        p2_reg   <= p2_next;
        pres_reg <= pres_next;
        best_reg <= best_next;
        bi_reg   <= bi_next;
        bj_reg   <= bj_next;
        pend_reg <= pend_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN1;
                end
            end
            ST_SCAN1:
            begin
                if (scan_idle)
                begin
                    state_next = ST_SCAN2;
                end
            end
            ST_SCAN2:
            begin
                if (scan_idle)
                begin
                    state_next = found_reg ? ST_SEEK1 : ST_FINISH;
                end
            end
            ST_SEEK1:
            begin
                if (seek_hit)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!pend_valid_reg || space)
                begin
                    state_next = ST_SCAN1;
                end
            end
            ST_FINISH:
            begin
                if (space)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        addr_next       = addr_reg;
        rdv_next        = 1'b0;
        ridx_next       = ridx_reg;
        p2_next         = p2_reg;
        n_next          = n_reg;
        pres_next       = pres_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        bi_next         = bi_reg;
        bj_next         = bj_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        eng             = '0;

        if (state_reg == ST_SCAN1 || state_reg == ST_SCAN2 || state_reg == ST_SEEK1)
        begin
            if (issue)
            begin
                addr_next = addr_reg + CNT_W'(1);
                rdv_next  = 1'b1;
                ridx_next = addr_reg[ADDR_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    addr_next       = '0;
                    p2_next         = '0;
                    n_next          = '0;
                    pres_next       = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_SCAN1:
            begin
                // mark every value left in the first sequence
                if (rdv_reg && in_range)
                begin
                    pres_next[rdata_cur] = 1'b1;
                end
                if (scan_idle)
                begin
                    addr_next  = p2_reg;
                    found_next = 1'b0;
                end
            end
            ST_SCAN2:
            begin
                // largest common value, strictly greater keeps the earliest index
                if (rdv_reg && in_range && pres_reg[rdata_cur]
                    && (!found_reg || rdata_cur > best_reg))
                begin
                    best_next  = rdata_cur;
                    bj_next    = ridx_reg;
                    found_next = 1'b1;
                end
                if (scan_idle)
                begin
                    addr_next = (n_reg == '0) ? '0 : CNT_W'(bi_reg) + CNT_W'(1);
                end
            end
            ST_SEEK1:
            begin
                if (seek_hit)
                begin
                    bi_next  = ridx_reg;
                    rdv_next = 1'b0;
                end
            end
            ST_PUSH:
            begin
                if (!pend_valid_reg || space)
                begin
                    eng.push        = pend_valid_reg;
                    eng.res.element = pend_reg;
                    pend_next       = best_reg;
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + CNT_W'(1);
                    p2_next         = CNT_W'(bj_reg) + CNT_W'(1);
                    addr_next       = CNT_W'(bi_reg) + CNT_W'(1);
                    pres_next       = '0;
                end
            end
            ST_FINISH:
            begin
                if (space)
                begin
                    eng.push     = 1'b1;
                    eng.done     = 1'b1;
                    eng.res.last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        eng.res.element = pend_reg;
                        eng.res.length  = LEN_W'(n_reg);
                    end
                    else
                    begin
                        eng.res.empty_res = 1'b1;
                    end
                end
            end
            default:
            begin
                rdv_next = 1'b0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) eng.push |-> space)
        else $error("result pushed without room in the output register");

    assert property (@(posedge clk) disable iff (!rst_n) n_reg <= CNT_W'(MAX_LEN))
        else $error("emitted count beyond sequence capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> found_reg)
        else $error("push state reached without a common value");

    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == ST_IDLE))
        else $error("run started while the engine is busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEEK1) |-> !scan_idle)
        else $error("seek ran off the end of the first sequence");

endmodule

### rtl/lex_largest_common_subsequence.sv
// append transaction: accepted while no run is in progress, no result
// run transaction: each emitted value takes three sequential single-port read scans of the
//   element memories (first sequence, second sequence, seek in the first); a final result
//   marked last ends the run; busy for the whole run, appends wait until it ends
// reset: asynchronous active low, clears counts, engine state and output valid;
//   the element memories are not cleared
module lex_largest_common_subsequence (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  lcs_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output lcs_pkg::result_t result
);
    import lcs_pkg::*;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt1_reg, cnt1_next;
    logic [CNT_W-1:0] cnt2_reg, cnt2_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic              accept;
    logic              value_ok;
    logic              we1, we2;
    logic              start;
    logic              space;
    logic [ADDR_W-1:0] raddr;
    logic [VAL_W-1:0]  rdata1, rdata2;
    eng_out_t          eng;

    // input side: no new transaction while a run is in progress
    assign item_ready = !busy_reg;
    assign accept     = item_valid && item_ready;

    // values above the limit are dropped, as are appends into a full store
    assign value_ok = (item.value <= VAL_W'(MAX_VALUE));
    assign we1 = accept && (item.kind == KIND_FIRST) && value_ok
                 && (cnt1_reg < CNT_W'(MAX_LEN));
    assign we2 = accept && (item.kind == KIND_SECOND) && value_ok
                 && (cnt2_reg < CNT_W'(MAX_LEN));
    assign start = accept && (item.kind == KIND_RUN);

    // output register: engine may refill it in the same cycle it drains
    assign space        = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    lcs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LEN)
    ) u_first_store (
        .clk   (clk),
        .we    (we1),
        .waddr (cnt1_reg[ADDR_W-1:0]),
        .wdata (item.value),
        .raddr (raddr),
        .rdata (rdata1)
    );

    lcs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_LEN)
    ) u_second_store (
        .clk   (clk),
        .we    (we2),
        .waddr (cnt2_reg[ADDR_W-1:0]),
        .wdata (item.value),
        .raddr (raddr),
        .rdata (rdata2)
    );

    lcs_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cnt1   (cnt1_reg),
        .cnt2   (cnt2_reg),
        .rdata1 (rdata1),
        .rdata2 (rdata2),
        .space  (space),
        .raddr  (raddr),
        .eng    (eng)
    );

    always_comb
    begin
        busy_next      = busy_reg;
        cnt1_next      = cnt1_reg;
        cnt2_next      = cnt2_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (we1)
        begin
            cnt1_next = cnt1_reg + CNT_W'(1);
        end
        if (we2)
        begin
            cnt2_next = cnt2_reg + CNT_W'(1);
        end
        if (start)
        begin
            busy_next = 1'b1;
        end

        // a run always empties both sequences
        if (eng.done)
        begin
            busy_next = 1'b0;
            cnt1_next = '0;
            cnt2_next = '0;
        end

        if (eng.push)
        begin
            out_valid_next = 1'b1;
            out_next       = eng.res;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt1_reg      <= cnt1_next;
            cnt2_reg      <= cnt2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
